[hw/rtl/abd_pkg.sv]
// Package for the anchor box decoder: payload types, register indexes,
// fixed anchor constants and the 2^x lookup used by the score and size paths.
// No dependencies.
package abd_pkg;

  // Pipeline depth of the score path and of the box path (registers).
  localparam int SCORE_LAT  = 12;
  localparam int BOX_LAT    = 7;
  localparam int DIV_STAGES = 9;

  localparam logic [6:0] GRID_MAX = 7'd64;
  localparam logic [1:0] LEVELS   = 2'd3;

  localparam logic [1:0] LEVEL_S32  = 2'd0;
  localparam logic [1:0] LEVEL_S64  = 2'd1;
  localparam logic [1:0] LEVEL_S128 = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CONF_THR  = 3'd0;
  localparam logic [2:0] CFG_SCALE     = 3'd1;
  localparam logic [2:0] CFG_X_OFFSET  = 3'd2;
  localparam logic [2:0] CFG_Y_OFFSET  = 3'd3;
  localparam logic [2:0] CFG_ORIG_W    = 3'd4;
  localparam logic [2:0] CFG_ORIG_H    = 3'd5;

  localparam logic [15:0] RST_CONF_THR = 16'd45875;
  localparam logic [23:0] RST_SCALE    = 24'd65536;
  localparam logic [12:0] RST_ORIG_W   = 13'd640;
  localparam logic [12:0] RST_ORIG_H   = 13'd480;

  // log2(e) in Q.16, 0.1 in Q.16, 0.2*log2(e) in Q.16.
  localparam logic [16:0] LOG2E      = 17'd94548;
  localparam logic [12:0] C_TENTH    = 13'd6554;
  localparam logic [14:0] C_FIFTH_L2 = 15'd18910;
  // Bias of 64 in Q.16 keeps the 2^x exponent word positive.
  localparam logic [22:0] POW2_BIAS  = 23'd4194304;
  // Exponent floor of -40 in Q.16.
  localparam logic [25:0] EXP_FLOOR  = 26'd2621440;

  typedef struct packed {
    logic        [1:0]  level;
    logic        [5:0]  cell_x;
    logic        [5:0]  cell_y;
    logic        [4:0]  anchor_slot;
    logic signed [15:0] bg_logit;
    logic signed [15:0] face_logit;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic signed [15:0] delta_w;
    logic signed [15:0] delta_h;
  } abd_in_t;

  typedef struct packed {
    logic [15:0] score;
    logic [11:0] box_left;
    logic [11:0] box_top;
    logic [11:0] box_right;
    logic [11:0] box_bottom;
  } abd_out_t;

  // Rebuilt anchor plus its deltas, handed to the box path.
  typedef struct packed {
    logic        [12:0] cx;
    logic        [12:0] cy;
    logic        [9:0]  a;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] dw;
    logic signed [15:0] dh;
  } anc_t;

  typedef struct packed {
    logic [23:0] scale;
    logic [10:0] x_off;
    logic [10:0] y_off;
    logic [11:0] x_hi;
    logic [11:0] y_hi;
  } box_cfg_t;

  typedef struct packed {
    logic [11:0] left;
    logic [11:0] top;
    logic [11:0] right;
    logic [11:0] bottom;
  } box_t;

  typedef logic [16:0] pow2_lut_t [256];

  // 2^-(2^-k) in Q0.16 for k = 1..8.
  localparam logic [15:0] POW2_NEG [8] = '{
    16'd46341, 16'd55109, 16'd60097, 16'd62757,
    16'd64132, 16'd64830, 16'd65183, 16'd65359
  };

  function automatic pow2_lut_t pow2_lut_gen();
    pow2_lut_t   lut;
    logic [32:0] m;
    for (int i = 0; i < 256; i++) begin
      m = 33'd65536;
      for (int k = 0; k < 8; k++) begin
        if (i[7-k]) m = (m * {17'd0, POW2_NEG[k]}) >> 16;
      end
      lut[i] = m[16:0];
    end
    return lut;
  endfunction

  localparam pow2_lut_t POW2_LUT = pow2_lut_gen();

  // 2^x in Q16.16 where w = x (Q.16) + 64.0, x within [-40, 15].
  function automatic logic [32:0] pow2_q16(input logic [22:0] w);
    logic [16:0] m;
    logic [15:0] g;
    logic [6:0]  ex;
    logic [32:0] mw;
    ex = w[22:16];
    g  = 16'(17'h10000 - {1'b0, w[15:0]});
    if (w[15:0] == 16'd0) m = 17'd32768;
    else                  m = POW2_LUT[g[15:8]];
    mw = {16'd0, m};
    if (ex >= 7'd63) return mw << (ex - 7'd63);
    return mw >> (7'd63 - ex);
  endfunction

  // Largest pixel index for an image size register.
  function automatic logic [11:0] clamp_hi(input logic [12:0] lim);
    if (lim == 13'd0)     return 12'd0;
    if (lim >= 13'd4096)  return 12'd4095;
    return 12'(lim - 13'd1);
  endfunction

endpackage

[hw/rtl/abd_stream_if.sv]
// Valid/ready stream interface used for the anchor and result channels.
// Payload type comes in as a type parameter, usually from abd_pkg.
interface abd_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/abd_score_pipe.sv]
// Score path: |face - bg| scaled by log2(e), 2^-x lookup, a radix-4
// restoring divider for 2^32 / (1 + e), then threshold compare. Uses abd_pkg.
module abd_score_pipe (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [16:0] d_i,
  input  logic        [15:0] thr_i,
  output logic        [15:0] score_o,
  output logic               pass_o
);

  logic [16:0] t;
  logic [33:0] u_full;
  logic [25:0] u_q;
  logic        neg_a_q;

  always_comb begin
    t      = d_i[16] ? 17'(-d_i) : 17'(d_i);
    u_full = {17'd0, t} * {17'd0, abd_pkg::LOG2E};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q     <= u_full[33:8];
      neg_a_q <= d_i[16];
    end
  end

  logic [25:0] uc;
  logic [22:0] w;
  logic [32:0] e_full;
  logic [17:0] den_b_q;
  logic        neg_b_q;

  always_comb begin
    uc     = (u_q > abd_pkg::EXP_FLOOR) ? abd_pkg::EXP_FLOOR : u_q;
    w      = abd_pkg::POW2_BIAS - uc[22:0];
    e_full = abd_pkg::pow2_q16(w);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_b_q <= 18'd65536 + {1'b0, e_full[16:0]};
      neg_b_q <= neg_a_q;
    end
  end

  // Each divider stage retires two quotient bits; the remainder starts at
  // 2^14 so that the nine stages cover quotient bits 17 down to 0.
  logic [17:0] r_q   [abd_pkg::DIV_STAGES];
  logic [17:0] q_q   [abd_pkg::DIV_STAGES];
  logic [17:0] den_q [abd_pkg::DIV_STAGES];
  logic        neg_q [abd_pkg::DIV_STAGES];

  for (genvar s = 0; s < abd_pkg::DIV_STAGES; s++) begin : g_div
    logic [17:0] r_in, q_in, den_in, r1, r2, q1, q2;
    logic        neg_in;

    if (s == 0) begin : g_first
      assign r_in   = 18'd16384;
      assign q_in   = 18'd0;
      assign den_in = den_b_q;
      assign neg_in = neg_b_q;
    end else begin : g_next
      assign r_in   = r_q[s-1];
      assign q_in   = q_q[s-1];
      assign den_in = den_q[s-1];
      assign neg_in = neg_q[s-1];
    end

    always_comb begin
      r1 = {r_in[16:0], 1'b0};
      q1 = {q_in[16:0], 1'b0};
      if (r1 >= den_in) begin
        r1    = r1 - den_in;
        q1[0] = 1'b1;
      end
      r2 = {r1[16:0], 1'b0};
      q2 = {q1[16:0], 1'b0};
      if (r2 >= den_in) begin
        r2    = r2 - den_in;
        q2[0] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[s]   <= r2;
        q_q[s]   <= q2;
        den_q[s] <= den_in;
        neg_q[s] <= neg_in;
      end
    end
  end

  logic [16:0] p;
  logic [15:0] score;

  always_comb begin
    p = q_q[abd_pkg::DIV_STAGES-1][16:0];
    if (neg_q[abd_pkg::DIV_STAGES-1]) score = 16'(17'h10000 - p);
    else if (p[16])                   score = 16'hFFFF;
    else                              score = p[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      score_o <= score;
      pass_o  <= score > thr_i;
    end
  end

endmodule

[hw/rtl/abd_box_pipe.sv]
// Box path: centre offsets and exp-scaled sizes, corners, letterbox shift,
// scale multiply and clamp, then a delay line to line up with the score.
// Uses abd_pkg.
module abd_box_pipe (
  input  logic              clk_i,
  input  logic              en_i,
  input  abd_pkg::anc_t     anc_i,
  input  abd_pkg::box_cfg_t cfg_i,
  output abd_pkg::box_t     box_o
);

  localparam int DLY = abd_pkg::SCORE_LAT - abd_pkg::BOX_LAT;

  // Stage 1: delta times anchor size, log-size scaling.
  logic signed [26:0] mx, my;
  logic signed [31:0] pw_full, ph_full;
  logic signed [26:0] mx_q, my_q;
  logic signed [19:0] vw_q, vh_q;
  logic        [12:0] cx1_q, cy1_q;
  logic        [9:0]  a1_q;

  always_comb begin
    mx      = anc_i.dx * $signed({1'b0, anc_i.a});
    my      = anc_i.dy * $signed({1'b0, anc_i.a});
    pw_full = anc_i.dw * $signed({1'b0, abd_pkg::C_FIFTH_L2});
    ph_full = anc_i.dh * $signed({1'b0, abd_pkg::C_FIFTH_L2});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx_q  <= mx;
      my_q  <= my;
      vw_q  <= 20'(pw_full >>> 12);
      vh_q  <= 20'(ph_full >>> 12);
      cx1_q <= anc_i.cx;
      cy1_q <= anc_i.cy;
      a1_q  <= anc_i.a;
    end
  end

  // Stage 2: times 0.1, and 2^x for the sizes.
  logic signed [40:0] cxm, cym;
  logic signed [23:0] ww, wh;
  logic        [32:0] pw_full2, ph_full2;
  logic signed [40:0] cxm_q, cym_q;
  logic        [19:0] pw_q, ph_q;
  logic        [12:0] cx2_q, cy2_q;
  logic        [9:0]  a2_q;

  always_comb begin
    cxm      = mx_q * $signed({1'b0, abd_pkg::C_TENTH});
    cym      = my_q * $signed({1'b0, abd_pkg::C_TENTH});
    ww       = $signed({1'b0, abd_pkg::POW2_BIAS}) + 24'(vw_q);
    wh       = $signed({1'b0, abd_pkg::POW2_BIAS}) + 24'(vh_q);
    pw_full2 = abd_pkg::pow2_q16(ww[22:0]);
    ph_full2 = abd_pkg::pow2_q16(wh[22:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cxm_q <= cxm;
      cym_q <= cym;
      pw_q  <= pw_full2[19:0];
      ph_q  <= ph_full2[19:0];
      cx2_q <= cx1_q;
      cy2_q <= cy1_q;
      a2_q  <= a1_q;
    end
  end

  // Stage 3: centres in Q.16 and half sizes.
  logic        [29:0] hw_full, hh_full;
  logic signed [32:0] ctrx_q, ctry_q;
  logic        [28:0] hw_q, hh_q;

  always_comb begin
    hw_full = pw_q * {10'd0, a2_q};
    hh_full = ph_q * {10'd0, a2_q};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctrx_q <= $signed({4'd0, cx2_q, 16'd0}) + 33'(cxm_q >>> 12);
      ctry_q <= $signed({4'd0, cy2_q, 16'd0}) + 33'(cym_q >>> 12);
      hw_q   <= hw_full[29:1];
      hh_q   <= hh_full[29:1];
    end
  end

  // Lanes: left, top, right, bottom.
  logic signed [33:0] cor_q  [4];
  logic signed [18:0] sub_q  [4];
  logic signed [43:0] prod_q [4];
  logic        [11:0] px_q   [4];

  logic signed [33:0] neg_c  [4];
  logic signed [17:0] xi     [4];
  logic        [10:0] off    [4];
  logic        [11:0] hi     [4];
  logic        [27:0] pu     [4];

  always_comb begin
    off[0] = cfg_i.x_off;  off[2] = cfg_i.x_off;
    off[1] = cfg_i.y_off;  off[3] = cfg_i.y_off;
    hi[0]  = cfg_i.x_hi;   hi[2]  = cfg_i.x_hi;
    hi[1]  = cfg_i.y_hi;   hi[3]  = cfg_i.y_hi;
    for (int i = 0; i < 4; i++) begin
      // Truncate toward zero to whole pixels.
      neg_c[i] = -cor_q[i];
      if (cor_q[i][33]) xi[i] = -18'(neg_c[i] >>> 16);
      else              xi[i] = 18'(cor_q[i] >>> 16);
      pu[i] = prod_q[i][43:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cor_q[0] <= 34'(ctrx_q) - $signed({5'd0, hw_q});
      cor_q[1] <= 34'(ctry_q) - $signed({5'd0, hh_q});
      cor_q[2] <= 34'(ctrx_q) + $signed({5'd0, hw_q});
      cor_q[3] <= 34'(ctry_q) + $signed({5'd0, hh_q});
      for (int i = 0; i < 4; i++) begin
        sub_q[i]  <= 19'(xi[i]) - $signed({8'd0, off[i]});
        prod_q[i] <= 44'(sub_q[i]) * 44'($signed({1'b0, cfg_i.scale}));
        if (prod_q[i][43])                  px_q[i] <= 12'd0;
        else if (pu[i] > {16'd0, hi[i]})    px_q[i] <= hi[i];
        else                                px_q[i] <= pu[i][11:0];
      end
    end
  end

  abd_pkg::box_t dly_q [DLY];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dly_q[0] <= '{left: px_q[0], top: px_q[1], right: px_q[2], bottom: px_q[3]};
      for (int i = 1; i < DLY; i++) dly_q[i] <= dly_q[i-1];
    end
  end

  assign box_o = dly_q[DLY-1];

endmodule

[hw/rtl/ssd_anchor_box_decode.sv]
// Anchor box decoder for a two-class SSD face detector.
// Takes one anchor transaction per cycle on in_s and emits a scored box on
// out_s when the face score beats the threshold; other anchors yield nothing.
// Configuration is a write-only port (cfg_we_i, cfg_idx_i, cfg_wdata_i),
// to be written only while no anchor is in flight.
// Throughput: one anchor per cycle unless a result waits on a stalled receiver.
// The depth is set by the score path, whose divider retires two quotient bits
// per stage over nine stages.
// The whole pipeline moves as one: while a result waits in the output register
// on a stalled receiver, every stage holds and in_s.ready drops in the same
// cycle; it rises again once that result is taken. Nothing is dropped or
// repeated.
// Reset clears all valid bits and loads the register reset values; the block
// accepts anchors in the first cycle after reset is released.
// Anchors with an unknown level, slot or cell produce no result.
// Depends on abd_pkg, abd_stream_if, abd_score_pipe and abd_box_pipe.
module ssd_anchor_box_decode (
  input  logic        clk_i,
  input  logic        rst_ni,
  abd_stream_if.sink   in_s,
  abd_stream_if.source out_s,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_wdata_i
);

  logic [15:0] conf_thr_q;
  logic [23:0] scale_q;
  logic [10:0] x_off_q, y_off_q;
  logic [12:0] orig_w_q, orig_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conf_thr_q <= abd_pkg::RST_CONF_THR;
      scale_q    <= abd_pkg::RST_SCALE;
      x_off_q    <= 11'd0;
      y_off_q    <= 11'd0;
      orig_w_q   <= abd_pkg::RST_ORIG_W;
      orig_h_q   <= abd_pkg::RST_ORIG_H;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        abd_pkg::CFG_CONF_THR: conf_thr_q <= cfg_wdata_i[15:0];
        abd_pkg::CFG_SCALE:    scale_q    <= cfg_wdata_i;
        abd_pkg::CFG_X_OFFSET: x_off_q    <= cfg_wdata_i[10:0];
        abd_pkg::CFG_Y_OFFSET: y_off_q    <= cfg_wdata_i[10:0];
        abd_pkg::CFG_ORIG_W:   orig_w_q   <= cfg_wdata_i[12:0];
        abd_pkg::CFG_ORIG_H:   orig_h_q   <= cfg_wdata_i[12:0];
        default: ;
      endcase
    end
  end

  abd_pkg::box_cfg_t box_cfg;

  always_comb begin
    box_cfg.scale = scale_q;
    box_cfg.x_off = x_off_q;
    box_cfg.y_off = y_off_q;
    box_cfg.x_hi  = abd_pkg::clamp_hi(orig_w_q);
    box_cfg.y_hi  = abd_pkg::clamp_hi(orig_h_q);
  end

  // The whole pipeline advances unless a held result blocks the output.
  logic            en;
  logic            out_valid_q;
  abd_pkg::abd_out_t out_q;

  assign en         = !out_valid_q || out_s.ready;
  assign in_s.ready = en;

  // Anchor geometry from level, cell and slot.
  logic          geo_ok;
  abd_pkg::anc_t anc;

  always_comb begin
    geo_ok = 1'b0;
    anc.cx = 13'd0;
    anc.cy = 13'd0;
    anc.a  = 10'd0;
    anc.dx = in_s.data.delta_x;
    anc.dy = in_s.data.delta_y;
    anc.dw = in_s.data.delta_w;
    anc.dh = in_s.data.delta_h;
    unique case (in_s.data.level)
      abd_pkg::LEVEL_S32: begin
        anc.cx = {2'd0, in_s.data.cell_x, 5'd0};
        anc.cy = {2'd0, in_s.data.cell_y, 5'd0};
        if (in_s.data.anchor_slot < 5'd16) begin
          geo_ok = 1'b1;
          anc.a  = 10'd33;
          anc.cx = anc.cx + {8'd0, in_s.data.anchor_slot[1:0], 3'd0};
          anc.cy = anc.cy + {8'd0, in_s.data.anchor_slot[3:2], 3'd0};
        end else if (in_s.data.anchor_slot < 5'd20) begin
          geo_ok = 1'b1;
          anc.a  = 10'd65;
          anc.cx = anc.cx + {8'd0, in_s.data.anchor_slot[0], 4'd0};
          anc.cy = anc.cy + {8'd0, in_s.data.anchor_slot[1], 4'd0};
        end else if (in_s.data.anchor_slot == 5'd20) begin
          geo_ok = 1'b1;
          anc.a  = 10'd129;
          anc.cx = anc.cx + 13'd16;
          anc.cy = anc.cy + 13'd16;
        end
      end
      abd_pkg::LEVEL_S64: begin
        geo_ok = (in_s.data.anchor_slot == 5'd0);
        anc.a  = 10'd257;
        anc.cx = {1'b0, in_s.data.cell_x, 6'd0} + 13'd32;
        anc.cy = {1'b0, in_s.data.cell_y, 6'd0} + 13'd32;
      end
      abd_pkg::LEVEL_S128: begin
        geo_ok = (in_s.data.anchor_slot == 5'd0);
        anc.a  = 10'd513;
        anc.cx = {in_s.data.cell_x, 7'd0} + 13'd64;
        anc.cy = {in_s.data.cell_y, 7'd0} + 13'd64;
      end
      default: geo_ok = 1'b0;
    endcase
    if (in_s.data.level >= abd_pkg::LEVELS ||
        {1'b0, in_s.data.cell_x} >= abd_pkg::GRID_MAX ||
        {1'b0, in_s.data.cell_y} >= abd_pkg::GRID_MAX) begin
      geo_ok = 1'b0;
    end
  end

  logic                v1_q;
  abd_pkg::anc_t       anc1_q;
  logic signed [16:0]  d1_q;
  logic [abd_pkg::SCORE_LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      vld_q <= '0;
    end else if (en) begin
      v1_q  <= in_s.valid && geo_ok;
      vld_q <= {vld_q[abd_pkg::SCORE_LAT-2:0], v1_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      anc1_q <= anc;
      d1_q   <= 17'(in_s.data.face_logit) - 17'(in_s.data.bg_logit);
    end
  end

  logic [15:0]   score;
  logic          pass;
  abd_pkg::box_t box;

  abd_score_pipe u_score (
    .clk_i   (clk_i),
    .en_i    (en),
    .d_i     (d1_q),
    .thr_i   (conf_thr_q),
    .score_o (score),
    .pass_o  (pass)
  );

  abd_box_pipe u_box (
    .clk_i (clk_i),
    .en_i  (en),
    .anc_i (anc1_q),
    .cfg_i (box_cfg),
    .box_o (box)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[abd_pkg::SCORE_LAT-1] && pass;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.score      <= score;
      out_q.box_left   <= box.left;
      out_q.box_top    <= box.top;
      out_q.box_right  <= box.right;
      out_q.box_bottom <= box.bottom;
    end
  end

  assign out_s.valid = out_valid_q;
  assign out_s.data  = out_q;

endmodule

[bench/testbench.sv]
// Self-checking bench for ssd_anchor_box_decode: stimulus table, random anchors
// under several register settings, and a scoreboard fed by a bit-exact predictor.
// Depends on abd_pkg, abd_stream_if and the decoder RTL.
`timescale 1ns / 1ps

module testbench;

  typedef enum logic [1:0] {ROW_NONE, ROW_GIVEN, ROW_PREDICT} row_kind_e;

  typedef struct {
    abd_pkg::abd_in_t  anchor;
    row_kind_e         kind;
    abd_pkg::abd_out_t box;
  } stim_row_t;

  localparam longint unsigned NEG_POW[8] = '{
    46341, 55109, 60097, 62757, 64132, 64830, 65183, 65359
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = abd_pkg::CFG_CONF_THR;
  logic [23:0] cfg_wdata_i = '0;

  abd_stream_if #(.payload_t(abd_pkg::abd_in_t))  anchor_if ();
  abd_stream_if #(.payload_t(abd_pkg::abd_out_t)) box_if ();

  ssd_anchor_box_decode DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_s        (anchor_if),
    .out_s       (box_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the decoder's registers.
  longint thr_q, scale_q, xoff_q, yoff_q, width_q, height_q;

  abd_pkg::abd_out_t expected_boxes[$];
  int       errors = 0;
  bit       calm = 1'b0;
  bit       hold_req = 1'b0;
  bit       hold_done = 1'b0;
  int       burst_left = 0;

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // 2^(v/65536) in Q16.16 with the exponent clamped to [-40, 15].
  function automatic longint exp2_q16(input longint v);
    longint w, n, sh;
    longint unsigned f, g, m;
    if (v < -40 * 65536) v = -40 * 65536;
    if (v > 15 * 65536) v = 15 * 65536;
    w = v + 64 * 65536;
    n = (w >>> 16) - 64;
    f = w & 'hFFFF;
    g = 65536 - f;
    if (g == 65536) begin
      m = 32768;
    end else begin
      m = 65536;
      for (int k = 0; k < 8; k++) if (g[15-k]) m = (m * NEG_POW[k]) >> 16;
    end
    sh = n + 1;
    if (sh >= 0) return longint'(m << sh);
    return longint'(m >> (-sh));
  endfunction

  function automatic logic [11:0] to_pixel(input longint corner, input longint off,
                                           input longint lim);
    longint xi, p;
    xi = (corner >= 0) ? (corner >>> 16) : -((-corner) >>> 16);
    if (lim == 0) lim = 1;
    if (lim > 4096) lim = 4096;
    p = (xi - off) * scale_q;
    if (p < 0) return 12'd0;
    p = p >>> 16;
    if (p > lim - 1) p = lim - 1;
    return p[11:0];
  endfunction

  // Returns 1 and the scored box when the anchor clears the threshold.
  function automatic bit decode_anchor(input abd_pkg::abd_in_t it,
                                       output abd_pkg::abd_out_t r);
    longint cx, cy, sz, a, d, t, u, e, p, sc, ctrx, ctry, hw, hh;
    longint unsigned i;
    r = '0;
    if (it.level > 2) return 0;
    if (it.level == abd_pkg::LEVEL_S32) begin
      if (it.anchor_slot < 16) begin
        sz = 32;
        cx = it.cell_x * 32 + (it.anchor_slot & 3) * 8;
        cy = it.cell_y * 32 + (it.anchor_slot >> 2) * 8;
      end else if (it.anchor_slot < 20) begin
        i = it.anchor_slot - 16;
        sz = 64;
        cx = it.cell_x * 32 + (i & 1) * 16;
        cy = it.cell_y * 32 + (i >> 1) * 16;
      end else if (it.anchor_slot == 20) begin
        sz = 128;
        cx = it.cell_x * 32 + 16;
        cy = it.cell_y * 32 + 16;
      end else begin
        return 0;
      end
    end else if (it.anchor_slot != 0) begin
      return 0;
    end else if (it.level == abd_pkg::LEVEL_S64) begin
      sz = 256;
      cx = it.cell_x * 64 + 32;
      cy = it.cell_y * 64 + 32;
    end else begin
      sz = 512;
      cx = it.cell_x * 128 + 64;
      cy = it.cell_y * 128 + 64;
    end
    d = longint'($signed(it.face_logit)) - longint'($signed(it.bg_logit));
    t = (d < 0) ? -d : d;
    u = (t * 94548) >>> 8;
    e = exp2_q16(-u);
    p = (64'sd1 <<< 32) / (65536 + e);
    if (d >= 0) sc = (p > 65535) ? 65535 : p;
    else        sc = 65536 - p;
    if (sc <= thr_q) return 0;
    a = sz + 1;
    ctrx = cx * 65536 + ((longint'($signed(it.delta_x)) * a * 6554) >>> 12);
    ctry = cy * 65536 + ((longint'($signed(it.delta_y)) * a * 6554) >>> 12);
    hw = (exp2_q16((longint'($signed(it.delta_w)) * 18910) >>> 12) * a) >>> 1;
    hh = (exp2_q16((longint'($signed(it.delta_h)) * 18910) >>> 12) * a) >>> 1;
    r.score      = sc[15:0];
    r.box_left   = to_pixel(ctrx - hw, xoff_q, width_q);
    r.box_top    = to_pixel(ctry - hh, yoff_q, height_q);
    r.box_right  = to_pixel(ctrx + hw, xoff_q, width_q);
    r.box_bottom = to_pixel(ctry + hh, yoff_q, height_q);
    return 1;
  endfunction

  function automatic abd_pkg::abd_in_t make_anchor(input int lvl, input int cx, input int cy,
                                          input int slot, input int bg, input int face,
                                          input int dx, input int dy, input int dw,
                                          input int dh);
    abd_pkg::abd_in_t it;
    it.level = lvl[1:0];
    it.cell_x = cx[5:0];
    it.cell_y = cy[5:0];
    it.anchor_slot = slot[4:0];
    it.bg_logit = bg[15:0];
    it.face_logit = face[15:0];
    it.delta_x = dx[15:0];
    it.delta_y = dy[15:0];
    it.delta_w = dw[15:0];
    it.delta_h = dh[15:0];
    return it;
  endfunction

  function automatic abd_pkg::abd_in_t random_anchor();
    abd_pkg::abd_in_t it;
    it = make_anchor($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom);
    if ($urandom_range(0, 9) == 0) return it;  // raw noise, mostly rejected
    it.level = 2'($urandom_range(0, 2));
    it.anchor_slot = (it.level == abd_pkg::LEVEL_S32) ? 5'($urandom_range(0, 20)) : 5'd0;
    if ($urandom_range(0, 1)) begin
      it.delta_x = 16'($urandom_range(0, 16383) - 8192);
      it.delta_y = 16'($urandom_range(0, 16383) - 8192);
      it.delta_w = 16'($urandom_range(0, 16383) - 8192);
      it.delta_h = 16'($urandom_range(0, 16383) - 8192);
    end
    return it;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input longint value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value[23:0];
    case (idx)
      abd_pkg::CFG_CONF_THR: thr_q    = value & 'hFFFF;
      abd_pkg::CFG_SCALE:    scale_q  = value & 'hFFFFFF;
      abd_pkg::CFG_X_OFFSET: xoff_q   = value & 'h7FF;
      abd_pkg::CFG_Y_OFFSET: yoff_q   = value & 'h7FF;
      abd_pkg::CFG_ORIG_W:   width_q  = value & 'h1FFF;
      abd_pkg::CFG_ORIG_H:   height_q = value & 'h1FFF;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(input longint thr, input longint scl, input longint xo,
                            input longint yo, input longint w, input longint h);
    write_reg(abd_pkg::CFG_CONF_THR, thr);
    write_reg(abd_pkg::CFG_SCALE, scl);
    write_reg(abd_pkg::CFG_X_OFFSET, xo);
    write_reg(abd_pkg::CFG_Y_OFFSET, yo);
    write_reg(abd_pkg::CFG_ORIG_W, w);
    write_reg(abd_pkg::CFG_ORIG_H, h);
  endtask

  // Offers one anchor and returns once it is taken, after an idle gap when a burst ends.
  task automatic send_anchor(input abd_pkg::abd_in_t it, input row_kind_e kind,
                             input abd_pkg::abd_out_t box);
    abd_pkg::abd_out_t r;
    anchor_if.valid <= 1'b1;
    anchor_if.data  <= it;
    do @(posedge clk_i); while (!anchor_if.ready);
    if (kind == ROW_GIVEN) expected_boxes.insert(expected_boxes.size(), box);
    else if (kind == ROW_PREDICT && decode_anchor(it, r))
      expected_boxes.insert(expected_boxes.size(), r);
    if (!calm && burst_left-- <= 0) begin
      anchor_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  // Lets the pipeline empty so that registers can be rewritten safely.
  task automatic drain();
    anchor_if.valid <= 1'b0;
    while (expected_boxes.size() != 0) @(posedge clk_i);
    repeat (abd_pkg::BOX_LAT + abd_pkg::SCORE_LAT + 6) @(posedge clk_i);
  endtask

  // Result side: checks each transaction and drives its own stall pattern.
  int stall_left = 0;
  int hold_left  = 0;
  always @(posedge clk_i) begin
    abd_pkg::abd_out_t want;
    if (rst_ni && box_if.valid && box_if.ready) begin
      if (expected_boxes.size() == 0) begin
        report("unexpected result, score", box_if.data.score, -1);
      end else begin
        want = expected_boxes.pop_front();
        if (box_if.data.score != want.score) report("score", box_if.data.score, want.score);
        if (box_if.data.box_left != want.box_left)
          report("box_left", box_if.data.box_left, want.box_left);
        if (box_if.data.box_top != want.box_top)
          report("box_top", box_if.data.box_top, want.box_top);
        if (box_if.data.box_right != want.box_right)
          report("box_right", box_if.data.box_right, want.box_right);
        if (box_if.data.box_bottom != want.box_bottom)
          report("box_bottom", box_if.data.box_bottom, want.box_bottom);
      end
    end
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 300;
      box_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      box_if.ready <= 1'b0;
    end else if (calm) begin
      box_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      box_if.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 6);
      box_if.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    abd_pkg::abd_out_t none;
    abd_pkg::abd_out_t corner_box;
    longint    cfgs[8][6];
    int        counts[8];
    none = '0;
    corner_box = '{score: 16'd65535, box_left: 12'd0, box_top: 12'd0,
                   box_right: 12'd16, box_bottom: 12'd16};
    anchor_if.valid = 1'b0;
    anchor_if.data  = '0;
    thr_q = abd_pkg::RST_CONF_THR; scale_q = abd_pkg::RST_SCALE; xoff_q = 0; yoff_q = 0;
    width_q = abd_pkg::RST_ORIG_W; height_q = abd_pkg::RST_ORIG_H;

    // Certain face with zero deltas, neutral logits, certain background.
    rows.insert(rows.size(), '{make_anchor(0, 0, 0, 0, -32768, 32767, 0, 0, 0, 0),
                               ROW_GIVEN, corner_box});
    rows.insert(rows.size(), '{make_anchor(0, 5, 5, 3, 100, 100, 0, 0, 0, 0), ROW_NONE, none});
    rows.insert(rows.size(), '{make_anchor(1, 5, 5, 0, 32767, -32768, 0, 0, 0, 0),
                               ROW_NONE, none});
    // Unknown level, slot not valid for the level.
    rows.insert(rows.size(), '{make_anchor(3, 1, 1, 0, -32768, 32767, 0, 0, 0, 0),
                               ROW_NONE, none});
    rows.insert(rows.size(), '{make_anchor(1, 1, 1, 1, -32768, 32767, 0, 0, 0, 0),
                               ROW_NONE, none});
    rows.insert(rows.size(), '{make_anchor(2, 1, 1, 31, -32768, 32767, 0, 0, 0, 0),
                               ROW_NONE, none});
    rows.insert(rows.size(), '{make_anchor(0, 1, 1, 21, -32768, 32767, 0, 0, 0, 0),
                               ROW_NONE, none});
    rows.insert(rows.size(), '{make_anchor(0, 2, 3, 31, -32768, 32767, 0, 0, 0, 0),
                               ROW_NONE, none});
    // Every slot class and the grid corners, with extreme deltas.
    rows.insert(rows.size(), '{make_anchor(0, 63, 63, 15, -500, 800, 32767, -32768, 32767,
                                           -32768), ROW_PREDICT, none});
    rows.insert(rows.size(), '{make_anchor(0, 10, 20, 16, 0, 1000, -32768, 32767, -32768,
                                           32767), ROW_PREDICT, none});
    rows.insert(rows.size(), '{make_anchor(0, 0, 63, 19, 0, 600, 4096, -4096, 2000, -2000),
                               ROW_PREDICT, none});
    rows.insert(rows.size(), '{make_anchor(0, 63, 0, 20, 0, 700, 0, 0, 8192, 8192),
                               ROW_PREDICT, none});
    rows.insert(rows.size(), '{make_anchor(1, 63, 63, 0, -100, 900, 100, 200, -300, 400),
                               ROW_PREDICT, none});
    rows.insert(rows.size(), '{make_anchor(2, 0, 0, 0, 0, 2000, -8000, -8000, 0, 0),
                               ROW_PREDICT, none});
    rows.insert(rows.size(), '{make_anchor(2, 63, 63, 0, 0, 2000, 32767, 32767, 32767, 32767),
                               ROW_PREDICT, none});
    rows.insert(rows.size(), '{make_anchor(1, 31, 42, 0, 255, 511, 1, -1, 1, -1),
                               ROW_PREDICT, none});

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_anchor(rows[i].anchor, rows[i].kind, rows[i].box);
    drain();

    cfgs[0] = '{45875, 65536, 0, 0, 640, 480};          counts[0] = 250;
    cfgs[1] = '{0, 1, 0, 0, 4096, 4096};                counts[1] = 200;
    cfgs[2] = '{0, 16777215, 2047, 2047, 8191, 8191};   counts[2] = 200;
    cfgs[3] = '{20000, 32768, 100, 40, 0, 0};           counts[3] = 200;
    cfgs[4] = '{65535, 65536, 0, 0, 640, 480};          counts[4] = 100;
    cfgs[5] = '{30000, 0, 7, 9, 1, 1};                  counts[5] = 150;
    cfgs[6] = '{10000, 98304, 16, 64, 1920, 1080};      counts[6] = 250;
    cfgs[7] = '{$urandom_range(0, 40000), $urandom_range(1, 200000), $urandom_range(0, 2047),
                $urandom_range(0, 2047), $urandom_range(1, 4096), $urandom_range(1, 4096)};
    counts[7] = 300;

    for (int ph = 0; ph < 8; ph++) begin
      set_config(cfgs[ph][0], cfgs[ph][1], cfgs[ph][2], cfgs[ph][3], cfgs[ph][4], cfgs[ph][5]);
      calm = (ph % 3 == 2);
      for (int n = 0; n < counts[ph]; n++) begin
        // A long receiver stall while anchors keep coming fills the pipeline.
        if (ph == 1 && n == 20) hold_req = 1'b1;
        send_anchor(random_anchor(), ROW_PREDICT, none);
      end
      drain();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
